// ----- hdl/text_console_writer_assert.svh -----
// ----------------------------------------------------------------------------
// text console writer assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TXCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("console writer check failed");

// next-cycle implication
`define TXCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("console writer sequence check failed");

`else

`define TXCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TXCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/txcw_pkg.sv -----
// ----------------------------------------------------------------------------
// txcw_pkg
// shared types, constants and controller/datapath command types
// ----------------------------------------------------------------------------
package txcw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // field widths
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int CELL_W  = CHAR_W + COLOR_W;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int IDX_W   = $clog2(CELLS + 1);

  typedef logic [COL_W-1:0]   col_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [IDX_W-1:0]   idx_t;

  // character and attribute codes
  localparam char_t  NEWLINE_CHAR = 8'h0A;
  localparam char_t  BLANK_CHAR   = 8'h20;
  localparam color_t RESET_COLOR  = 8'h0F;

  // operation codes
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2
  } func_t;

  // controller states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_COPY,
    S_FILL,
    S_PUT,
    S_DONE
  } state_t;

  // cursor update
  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ADVANCE,
    CUR_NEXT_LINE,
    CUR_NEXT_PUT,
    CUR_COL_ZERO
  } cur_op_t;

  // store write address select
  typedef enum logic [1:0] {
    WA_CURSOR,
    WA_NEXT_ROW,
    WA_COPY,
    WA_SWEEP
  } wa_sel_t;

  // store write data select
  typedef enum logic [2:0] {
    WD_INPUT,
    WD_SAVED,
    WD_COPY,
    WD_BLANK,
    WD_INIT
  } wd_sel_t;

  // store read address select
  typedef enum logic {
    RA_INPUT,
    RA_SWEEP
  } ra_sel_t;

  // sweep index update
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_INC,
    IDX_ZERO,
    IDX_COPY_START,
    IDX_LAST_ROW
  } idx_op_t;

  typedef struct packed {
    logic    accept;
    cur_op_t cur_op;
    logic    wr_en;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    logic    rd_en;
    ra_sel_t ra_sel;
    idx_op_t idx_op;
    logic    scroll_set;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_newline;
    logic col_at_end;
    logic row_last;
    logic read_in_range;
    logic idx_at_copy_start;
    logic idx_at_end;
    logic idx_at_last;
  } dp_status_t;

endpackage

// ----- hdl/txcw_ram.sv -----
// ----------------------------------------------------------------------------
// txcw_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module txcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/txcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// txcw_ctrl
// controller state machine: decodes operations, runs clear and scroll sweeps
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module txcw_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  txcw_pkg::dp_status_t  status,
  output txcw_pkg::ctrl_cmd_t   cmd
);

  txcw_pkg::state_t state_r, state_nxt;
  logic             put_pend_r, put_pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  txcw_pkg::func_t  func;
  logic             out_free;
  logic             scroll_start;
  logic             imm;
  logic             in_scroll_seq;
  logic             copy_last;

  assign func     = txcw_pkg::func_t'(in_func);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == txcw_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  // scroll sequence phases
  assign in_scroll_seq = (state_r == txcw_pkg::S_COPY) || (state_r == txcw_pkg::S_FILL) ||
                         (state_r == txcw_pkg::S_PUT);
  assign copy_last     = (state_r == txcw_pkg::S_COPY) && status.idx_at_end;

  // operation decode
  always_comb begin
    scroll_start = (func == txcw_pkg::FUNC_WRITE) && status.row_last &&
                   (status.is_newline || status.col_at_end);
    imm = !(scroll_start || func == txcw_pkg::FUNC_CLEAR ||
            func == txcw_pkg::FUNC_READ);
  end

  // next state
  always_comb begin
    state_nxt    = state_r;
    put_pend_nxt = put_pend_r;
    unique case (state_r)
      txcw_pkg::S_INIT: begin
        if (status.idx_at_last) begin
          state_nxt = txcw_pkg::S_IDLE;
        end
      end
      txcw_pkg::S_IDLE: begin
        if (in_valid) begin
          priority if (scroll_start) begin
            state_nxt    = txcw_pkg::S_COPY;
            put_pend_nxt = !status.is_newline;
          end else if (func == txcw_pkg::FUNC_CLEAR) begin
            state_nxt = txcw_pkg::S_FILL;
          end else if (func == txcw_pkg::FUNC_READ) begin
            state_nxt = txcw_pkg::S_DONE;
          end else if (!out_free) begin
            state_nxt = txcw_pkg::S_DONE;
          end else begin
            state_nxt = txcw_pkg::S_IDLE;
          end
        end
      end
      txcw_pkg::S_COPY: begin
        if (status.idx_at_end) begin
          state_nxt = txcw_pkg::S_FILL;
        end
      end
      txcw_pkg::S_FILL: begin
        if (status.idx_at_last) begin
          state_nxt = put_pend_r ? txcw_pkg::S_PUT : txcw_pkg::S_DONE;
        end
      end
      txcw_pkg::S_PUT: begin
        state_nxt    = txcw_pkg::S_DONE;
        put_pend_nxt = 1'b0;
      end
      txcw_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = txcw_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = txcw_pkg::S_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd            = '0;
    cmd.cur_op     = txcw_pkg::CUR_HOLD;
    cmd.wa_sel     = txcw_pkg::WA_CURSOR;
    cmd.wd_sel     = txcw_pkg::WD_INPUT;
    cmd.ra_sel     = txcw_pkg::RA_INPUT;
    cmd.idx_op     = txcw_pkg::IDX_HOLD;
    unique case (state_r)
      txcw_pkg::S_INIT: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = txcw_pkg::WA_SWEEP;
        cmd.wd_sel = txcw_pkg::WD_INIT;
        cmd.idx_op = txcw_pkg::IDX_INC;
      end
      txcw_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept   = 1'b1;
          cmd.load_out = imm && out_free;
          unique case (func)
            txcw_pkg::FUNC_WRITE: begin
              priority if (scroll_start) begin
                cmd.cur_op     = txcw_pkg::CUR_COL_ZERO;
                cmd.scroll_set = 1'b1;
                cmd.idx_op     = txcw_pkg::IDX_COPY_START;
              end else if (status.is_newline) begin
                cmd.cur_op = txcw_pkg::CUR_NEXT_LINE;
              end else if (status.col_at_end) begin
                cmd.cur_op = txcw_pkg::CUR_NEXT_PUT;
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = txcw_pkg::WA_NEXT_ROW;
              end else begin
                cmd.cur_op = txcw_pkg::CUR_ADVANCE;
                cmd.wr_en  = 1'b1;
              end
            end
            txcw_pkg::FUNC_CLEAR: begin
              cmd.idx_op = txcw_pkg::IDX_ZERO;
            end
            txcw_pkg::FUNC_READ: begin
              cmd.rd_en = status.read_in_range;
            end
            default: begin
              cmd.cur_op = txcw_pkg::CUR_HOLD;
            end
          endcase
        end
      end
      txcw_pkg::S_COPY: begin
        cmd.rd_en  = !status.idx_at_end;
        cmd.ra_sel = txcw_pkg::RA_SWEEP;
        cmd.wr_en  = !status.idx_at_copy_start;
        cmd.wa_sel = txcw_pkg::WA_COPY;
        cmd.wd_sel = txcw_pkg::WD_COPY;
        cmd.idx_op = status.idx_at_end ? txcw_pkg::IDX_LAST_ROW : txcw_pkg::IDX_INC;
      end
      txcw_pkg::S_FILL: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = txcw_pkg::WA_SWEEP;
        cmd.wd_sel = txcw_pkg::WD_BLANK;
        cmd.idx_op = txcw_pkg::IDX_INC;
      end
      txcw_pkg::S_PUT: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = txcw_pkg::WA_CURSOR;
        cmd.wd_sel = txcw_pkg::WD_SAVED;
        cmd.cur_op = txcw_pkg::CUR_ADVANCE;
      end
      txcw_pkg::S_DONE: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd.load_out = 1'b0;
      end
    endcase
  end

  // result register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= txcw_pkg::S_INIT;
      put_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      put_pend_r  <= put_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a result is only loaded into a free output register
  `TXCW_ASSERT_IMP(a_load_when_free, clk, rst_n, cmd.load_out, !out_valid_r || out_ready)
  // a pending wrapped character only lives through the scroll sequence
  `TXCW_ASSERT_IMP(a_put_pend_scope, clk, rst_n, put_pend_r, in_scroll_seq)
  // the row copy is always followed by the bottom row fill
  `TXCW_ASSERT_NXT(a_copy_then_fill, clk, rst_n, copy_last, state_r == txcw_pkg::S_FILL)

endmodule

// ----- hdl/txcw_dpath.sv -----
// ----------------------------------------------------------------------------
// txcw_dpath
// datapath: cursor, color register, sweep index, screen store, result register
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module txcw_dpath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [7:0]             cfg_wr_data,
  input  logic [7:0]             in_char_code,
  input  logic [6:0]             in_cell_col,
  input  logic [4:0]             in_cell_row,
  input  txcw_pkg::ctrl_cmd_t    cmd,
  output txcw_pkg::dp_status_t   status,
  output logic [6:0]             out_cursor_col,
  output logic [4:0]             out_cursor_row,
  output logic                   out_scrolled,
  output logic [7:0]             out_read_char,
  output logic [7:0]             out_read_color
);

  txcw_pkg::col_t   cursor_col_r, cursor_col_nxt;
  txcw_pkg::row_t   cursor_row_r, cursor_row_nxt;
  txcw_pkg::color_t text_color_r;
  txcw_pkg::idx_t   idx_r, idx_nxt;
  txcw_pkg::char_t  char_r;
  logic             scroll_r, scroll_nxt;
  logic             rd_sel_r, rd_sel_nxt;

  txcw_pkg::addr_t  row_base;
  txcw_pkg::addr_t  cursor_addr;
  txcw_pkg::addr_t  next_row_addr;
  txcw_pkg::addr_t  copy_addr;
  txcw_pkg::addr_t  sweep_addr;
  txcw_pkg::addr_t  in_addr;
  txcw_pkg::idx_t   copy_dst;
  txcw_pkg::addr_t  wr_addr;
  txcw_pkg::addr_t  rd_addr;
  txcw_pkg::cell_t  wr_data;
  txcw_pkg::cell_t  rd_data;

  txcw_pkg::col_t   out_cursor_col_r;
  txcw_pkg::row_t   out_cursor_row_r;
  logic             out_scrolled_r;
  txcw_pkg::char_t  out_read_char_r;
  txcw_pkg::color_t out_read_color_r;

  // status to controller
  always_comb begin
    status.is_newline        = (in_char_code == txcw_pkg::NEWLINE_CHAR);
    status.col_at_end        = (cursor_col_r >= txcw_pkg::col_t'(txcw_pkg::COLUMNS));
    status.row_last          = (cursor_row_r == txcw_pkg::row_t'(txcw_pkg::ROWS - 1));
    status.read_in_range     = (in_cell_col < txcw_pkg::col_t'(txcw_pkg::COLUMNS)) &&
                               (in_cell_row < txcw_pkg::row_t'(txcw_pkg::ROWS));
    status.idx_at_copy_start = (idx_r == txcw_pkg::idx_t'(txcw_pkg::COLUMNS));
    status.idx_at_end        = (idx_r == txcw_pkg::idx_t'(txcw_pkg::CELLS));
    status.idx_at_last       = (idx_r == txcw_pkg::idx_t'(txcw_pkg::CELLS - 1));
  end

  // cursor update
  always_comb begin
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    unique case (cmd.cur_op)
      txcw_pkg::CUR_HOLD: begin
        cursor_col_nxt = cursor_col_r;
      end
      txcw_pkg::CUR_ADVANCE: begin
        cursor_col_nxt = cursor_col_r + txcw_pkg::col_t'(1);
      end
      txcw_pkg::CUR_NEXT_LINE: begin
        cursor_col_nxt = '0;
        cursor_row_nxt = cursor_row_r + txcw_pkg::row_t'(1);
      end
      txcw_pkg::CUR_NEXT_PUT: begin
        cursor_col_nxt = txcw_pkg::col_t'(1);
        cursor_row_nxt = cursor_row_r + txcw_pkg::row_t'(1);
      end
      txcw_pkg::CUR_COL_ZERO: begin
        cursor_col_nxt = '0;
      end
      default: begin
        cursor_col_nxt = cursor_col_r;
      end
    endcase
  end

  // sweep index
  always_comb begin
    idx_nxt = idx_r;
    unique case (cmd.idx_op)
      txcw_pkg::IDX_HOLD:       idx_nxt = idx_r;
      txcw_pkg::IDX_INC:        idx_nxt = idx_r + txcw_pkg::idx_t'(1);
      txcw_pkg::IDX_ZERO:       idx_nxt = '0;
      txcw_pkg::IDX_COPY_START: idx_nxt = txcw_pkg::idx_t'(txcw_pkg::COLUMNS);
      txcw_pkg::IDX_LAST_ROW:   idx_nxt = txcw_pkg::idx_t'(txcw_pkg::CELLS - txcw_pkg::COLUMNS);
      default:                  idx_nxt = idx_r;
    endcase
  end

  // per-item flags, captured at transfer
  always_comb begin
    scroll_nxt = scroll_r;
    rd_sel_nxt = rd_sel_r;
    if (cmd.accept) begin
      scroll_nxt = cmd.scroll_set;
      rd_sel_nxt = cmd.rd_en;
    end
  end

  // store addresses
  always_comb begin
    row_base      = txcw_pkg::addr_t'(cursor_row_r) * txcw_pkg::addr_t'(txcw_pkg::COLUMNS);
    cursor_addr   = row_base + txcw_pkg::addr_t'(cursor_col_r);
    next_row_addr = row_base + txcw_pkg::addr_t'(txcw_pkg::COLUMNS);
    copy_dst      = idx_r - txcw_pkg::idx_t'(txcw_pkg::COLUMNS + 1);
    copy_addr     = copy_dst[txcw_pkg::ADDR_W-1:0];
    sweep_addr    = idx_r[txcw_pkg::ADDR_W-1:0];
    in_addr       = txcw_pkg::addr_t'(in_cell_row) * txcw_pkg::addr_t'(txcw_pkg::COLUMNS) +
                    txcw_pkg::addr_t'(in_cell_col);
  end

  // write port select
  always_comb begin
    unique case (cmd.wa_sel)
      txcw_pkg::WA_CURSOR:   wr_addr = cursor_addr;
      txcw_pkg::WA_NEXT_ROW: wr_addr = next_row_addr;
      txcw_pkg::WA_COPY:     wr_addr = copy_addr;
      txcw_pkg::WA_SWEEP:    wr_addr = sweep_addr;
      default:               wr_addr = cursor_addr;
    endcase
    unique case (cmd.wd_sel)
      txcw_pkg::WD_INPUT: wr_data = {text_color_r, in_char_code};
      txcw_pkg::WD_SAVED: wr_data = {text_color_r, char_r};
      txcw_pkg::WD_COPY:  wr_data = rd_data;
      txcw_pkg::WD_BLANK: wr_data = {text_color_r, txcw_pkg::BLANK_CHAR};
      txcw_pkg::WD_INIT:  wr_data = {txcw_pkg::RESET_COLOR, txcw_pkg::BLANK_CHAR};
      default:            wr_data = {text_color_r, txcw_pkg::BLANK_CHAR};
    endcase
  end

  assign rd_addr = (cmd.ra_sel == txcw_pkg::RA_SWEEP) ? sweep_addr : in_addr;

  // screen store
  txcw_ram #(
    .WIDTH (txcw_pkg::CELL_W),
    .DEPTH (txcw_pkg::CELLS)
  ) u_screen_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      text_color_r <= txcw_pkg::RESET_COLOR;
      idx_r        <= '0;
      scroll_r     <= 1'b0;
      rd_sel_r     <= 1'b0;
    end else begin
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      idx_r        <= idx_nxt;
      scroll_r     <= scroll_nxt;
      rd_sel_r     <= rd_sel_nxt;
      if (cfg_wr_en) begin
        text_color_r <= cfg_wr_data;
      end
    end
  end

  // saved character for a write that wraps through a scroll
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      char_r <= in_char_code;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_cursor_col_r <= cursor_col_nxt;
      out_cursor_row_r <= cursor_row_nxt;
      out_scrolled_r   <= scroll_nxt;
      out_read_char_r  <= rd_sel_nxt ? rd_data[txcw_pkg::CHAR_W-1:0] : '0;
      out_read_color_r <= rd_sel_nxt ? rd_data[txcw_pkg::CELL_W-1:txcw_pkg::CHAR_W] : '0;
    end
  end

  assign out_cursor_col = out_cursor_col_r;
  assign out_cursor_row = out_cursor_row_r;
  assign out_scrolled   = out_scrolled_r;
  assign out_read_char  = out_read_char_r;
  assign out_read_color = out_read_color_r;

  // cursor column never passes the wrap position
  `TXCW_ASSERT_IMP(a_col_bound, clk, rst_n, 1'b1, cursor_col_r <= txcw_pkg::col_t'(txcw_pkg::COLUMNS))
  // cursor row stays on screen
  `TXCW_ASSERT_IMP(a_row_bound, clk, rst_n, 1'b1, cursor_row_r < txcw_pkg::row_t'(txcw_pkg::ROWS))
  // a store at the cursor only happens with the cursor inside the row
  `TXCW_ASSERT_IMP(a_put_in_row, clk, rst_n, cmd.wr_en && (cmd.wa_sel == txcw_pkg::WA_CURSOR), cursor_col_r < txcw_pkg::col_t'(txcw_pkg::COLUMNS))

endmodule

// ----- hdl/text_console_writer.sv -----
// A character or a newline without scroll is accepted one per cycle with out_ready high; a
// cell read passes through a done state, so no new request is taken until its result is loaded.
// A scroll copies rows 1..24 up through the single store read port, then blanks the bottom row;
// a wrapped character is then written at the cursor. A clear blanks every cell of the store.
// Reset (rst_n, synchronous) zeroes the cursor, sets text_color to 15 and then runs a
// clearing pass over the store, during which in_ready stays low.
// ----------------------------------------------------------------------------
// text_console_writer
// text-mode console engine: screen store, cursor, scroll, clear and cell read
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [7:0] in_char_code,
  input  logic [6:0] in_cell_col,
  input  logic [4:0] in_cell_row,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_cursor_col,
  output logic [4:0] out_cursor_row,
  output logic       out_scrolled,
  output logic [7:0] out_read_char,
  output logic [7:0] out_read_color
);

  txcw_pkg::ctrl_cmd_t  cmd;
  txcw_pkg::dp_status_t status;

  // controller
  txcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  txcw_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_char_code   (in_char_code),
    .in_cell_col    (in_cell_col),
    .in_cell_row    (in_cell_row),
    .cmd            (cmd),
    .status         (status),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_scrolled   (out_scrolled),
    .out_read_char  (out_read_char),
    .out_read_color (out_read_color)
  );

endmodule

// ----- bench/tb_console_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console tracker
// shadow copy of the screen, cursor and text colour, and the queue of
// console status words owed by the block, checked in order of transfer
// ----------------------------------------------------------------------------
package tb_console_pkg;
  import txcw_pkg::*;

  // operation code with no meaning, the block only reports the cursor
  localparam logic [1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    col_t   cursor_col;
    row_t   cursor_row;
    logic   scrolled;
    char_t  read_char;
    color_t read_color;
  } console_status_t;

  class console_tracker;
    cell_t           screen_cells [CELLS];
    int              cur_col;
    int              cur_row;
    color_t          text_color;
    console_status_t owed_status [$];
    int              fail_count;

    function new();
      foreach (screen_cells[i]) screen_cells[i] = {RESET_COLOR, BLANK_CHAR};
      cur_col    = 0;
      cur_row    = 0;
      text_color = RESET_COLOR;
      fail_count = 0;
    endfunction

    function cell_t blank_cell();
      return {text_color, BLANK_CHAR};
    endfunction

    // column back to zero, next row, or scroll up when on the last row
    function bit advance_line();
      cur_col = 0;
      if (cur_row < ROWS - 1) begin
        cur_row++;
        return 1'b0;
      end
      for (int i = COLUMNS; i < CELLS; i++) screen_cells[i - COLUMNS] = screen_cells[i];
      for (int c = 0; c < COLUMNS; c++) screen_cells[(ROWS - 1) * COLUMNS + c] = blank_cell();
      return 1'b1;
    endfunction

    function int status_owed();
      return owed_status.size();
    endfunction

    // apply one accepted command and queue the status it must produce
    function void take_command(logic [1:0] func, char_t code, col_t col, row_t row);
      console_status_t st;
      cell_t           hit;
      st = '0;
      case (func)
        FUNC_WRITE: begin
          if (code == NEWLINE_CHAR) begin
            st.scrolled = advance_line();
          end else begin
            // wrap first when the previous character filled the line
            if (cur_col >= COLUMNS) st.scrolled = advance_line();
            screen_cells[cur_row * COLUMNS + cur_col] = {text_color, code};
            cur_col++;
          end
        end
        FUNC_CLEAR: begin
          foreach (screen_cells[i]) screen_cells[i] = blank_cell();
        end
        FUNC_READ: begin
          // out of range reads give zero
          if (col < COLUMNS && row < ROWS) begin
            hit           = screen_cells[row * COLUMNS + col];
            st.read_char  = hit[CHAR_W-1:0];
            st.read_color = hit[CELL_W-1:CHAR_W];
          end
        end
        default: begin
        end
      endcase
      st.cursor_col = col_t'(cur_col);
      st.cursor_row = row_t'(cur_row);
      owed_status.push_back(st);
    endfunction

    function void report(string what, console_status_t exp, console_status_t got);
      fail_count++;
      if (fail_count <= 10)
        $display("%s: exp col %0d row %0d scr %0d chr %02h clr %02h | got col %0d row %0d scr %0d chr %02h clr %02h",
                 what, exp.cursor_col, exp.cursor_row, exp.scrolled, exp.read_char,
                 exp.read_color, got.cursor_col, got.cursor_row, got.scrolled,
                 got.read_char, got.read_color);
    endfunction

    // compare one result transfer with the oldest owed status
    function void check_status(console_status_t got);
      console_status_t exp;
      if (owed_status.size() == 0) begin
        report("status with nothing owed", '0, got);
        return;
      end
      exp = owed_status.pop_front();
      if (got.cursor_col !== exp.cursor_col || got.cursor_row !== exp.cursor_row ||
          got.scrolled !== exp.scrolled || got.read_char !== exp.read_char ||
          got.read_color !== exp.read_color)
        report("status mismatch", exp, got);
    endfunction
  endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives console commands with random gaps on both channels, walks the text
// colour through several values and checks every status against the tracker
// ----------------------------------------------------------------------------
module tb_top;
  import txcw_pkg::*;
  import tb_console_pkg::*;

  localparam int STALL_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 600;
  localparam int SEGMENTS      = 6;
  localparam int SEGMENT_ITEMS = 225;
  localparam int TAIL_CYCLES   = 20;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       cfg_wr_en    = 1'b0;
  logic [7:0] cfg_wr_data  = '0;
  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic [1:0] in_func      = '0;
  logic [7:0] in_char_code = '0;
  logic [6:0] in_cell_col  = '0;
  logic [4:0] in_cell_row  = '0;
  logic       out_valid;
  logic       out_ready    = 1'b0;
  logic [6:0] out_cursor_col;
  logic [4:0] out_cursor_row;
  logic       out_scrolled;
  logic [7:0] out_read_char;
  logic [7:0] out_read_color;

  console_tracker tracker;

  int   snd_idle_pct = 30;
  int   rcv_idle_pct = 84;
  logic hold_armed   = 1'b0;
  logic hold_used    = 1'b0;
  int   hold_left    = 0;
  int   stuck_cycles = 0;

  always #5 clk = ~clk;

  text_console_writer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_char_code   (in_char_code),
    .in_cell_col    (in_cell_col),
    .in_cell_row    (in_cell_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_scrolled   (out_scrolled),
    .out_read_char  (out_read_char),
    .out_read_color (out_read_color)
  );

  // result side: check each transfer, random ready, one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_status(console_status_t'({out_cursor_col, out_cursor_row, out_scrolled,
                                              out_read_char, out_read_color}));
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_used) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // offer one command, optionally after a gap, and wait for its transfer
  task automatic send_item(input logic [1:0] func, input logic [7:0] code,
                           input logic [6:0] col, input logic [4:0] row);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < snd_idle_pct) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= func;
    in_char_code <= code;
    in_cell_col  <= col;
    in_cell_row  <= row;
    do @(posedge clk); while (!in_ready);
    tracker.take_command(func, code, col, row);
  endtask

  // stop offering and wait until every owed status has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.status_owed() != 0) @(posedge clk);
  endtask

  task automatic set_text_color(input color_t value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    tracker.text_color = value;
    cfg_wr_en <= 1'b0;
  endtask

  // mostly text with some newlines, reads near the cursor, rare clears
  task automatic send_random();
    int         pick;
    int         aim;
    logic [1:0] func;
    char_t      code;
    col_t       col;
    row_t       row;
    pick = $urandom_range(99);
    func = FUNC_WRITE;
    code = char_t'($urandom_range(255));
    col  = col_t'($urandom_range(127));
    row  = row_t'($urandom_range(31));
    if (pick < 55) begin
      func = FUNC_WRITE;
    end else if (pick < 60) begin
      code = NEWLINE_CHAR;
    end else if (pick < 85) begin
      func = FUNC_READ;
      aim  = $urandom_range(9);
      if (aim < 6) begin
        col = col_t'($urandom_range(COLUMNS - 1));
        row = row_t'(tracker.cur_row);
        if (tracker.cur_row > 0) row = row_t'(tracker.cur_row - $urandom_range(1));
      end else if (aim < 9) begin
        col = col_t'($urandom_range(COLUMNS - 1));
        row = row_t'($urandom_range(ROWS - 1));
      end
    end else if (pick < 86) begin
      func = FUNC_CLEAR;
    end else if (pick < 89) begin
      func = FUNC_NONE;
    end else begin
      code = char_t'($urandom_range(126, 32));
    end
    send_item(func, code, col, row);
  endtask

  initial begin
    color_t seg_color;
    tracker = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset contents, field extremes, out of range reads, no-op code
    send_item(FUNC_READ, 8'h00, 7'd0, 5'd0);
    send_item(FUNC_READ, 8'hFF, 7'd79, 5'd24);
    send_item(FUNC_WRITE, 8'h00, 7'd0, 5'd0);
    send_item(FUNC_WRITE, 8'hFF, 7'd127, 5'd31);
    send_item(FUNC_WRITE, NEWLINE_CHAR, 7'd0, 5'd0);
    send_item(FUNC_WRITE, 8'h41, 7'd0, 5'd0);
    send_item(FUNC_READ, 8'h00, 7'd0, 5'd0);
    send_item(FUNC_READ, 8'h00, 7'd1, 5'd0);
    send_item(FUNC_READ, 8'h00, 7'd0, 5'd1);
    send_item(FUNC_READ, 8'h00, 7'd80, 5'd0);
    send_item(FUNC_READ, 8'hFF, 7'd127, 5'd31);
    send_item(FUNC_READ, 8'h00, 7'd0, 5'd25);
    send_item(FUNC_NONE, 8'hFF, 7'd127, 5'd31);
    send_item(FUNC_NONE, 8'h00, 7'd0, 5'd0);

    // clear with the lowest colour, then newline with all-ones side fields
    set_text_color(8'h00);
    send_item(FUNC_CLEAR, 8'hFF, 7'd127, 5'd31);
    send_item(FUNC_READ, 8'h00, 7'd5, 5'd5);
    send_item(FUNC_WRITE, NEWLINE_CHAR, 7'd127, 5'd31);
    send_item(FUNC_WRITE, 8'h7E, 7'd0, 5'd0);

    set_text_color(8'hFF);
    send_item(FUNC_WRITE, 8'h55, 7'd0, 5'd0);
    send_item(FUNC_READ, 8'h00, 7'd1, 5'd2);
    send_item(FUNC_CLEAR, 8'h00, 7'd0, 5'd0);
    send_item(FUNC_READ, 8'h00, 7'd79, 5'd24);

    // random segments: receiver idles, then sender idles, then neither
    for (int s = 0; s < SEGMENTS; s++) begin
      seg_color = color_t'($urandom_range(255));
      if (s == 1) seg_color = 8'hFF;
      if (s == 4) seg_color = 8'h00;
      set_text_color(seg_color);
      case (s / 2)
        0: begin
          snd_idle_pct = 30;
          rcv_idle_pct = 84;
        end
        1: begin
          snd_idle_pct = 84;
          rcv_idle_pct = 30;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      if (s == 4) hold_armed <= 1'b1;
      repeat (SEGMENT_ITEMS) send_random();
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.status_owed() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- text_console_writer.f -----
+incdir+hdl
hdl/txcw_pkg.sv
hdl/txcw_ram.sv
hdl/txcw_ctrl.sv
hdl/txcw_dpath.sv
hdl/text_console_writer.sv
bench/tb_console_pkg.sv
bench/tb_top.sv
